// File: sv/image_laplacian_stencil_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Laplacian stencil block
// Same-cycle and next-cycle implication checks with asynchronous reset.
// ---------------------------------------------------------------------------
`ifndef IMAGE_LAPLACIAN_STENCIL_TOP_ASSERT_SVH
`define IMAGE_LAPLACIAN_STENCIL_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define ILS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define ILS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ils_pkg.sv
// ---------------------------------------------------------------------------
// ils_pkg
// Shared types, widths and register codes of the Laplacian stencil block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SIZE_W     = 11;
	localparam int COEF_W     = 24;
	localparam int IDX_W      = 10;
	localparam int RES_W      = 32;
	localparam int DIFF_W     = 18;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = DIFF_W + COEF_W + 1;
	localparam int SUM_W      = PROD_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int NUM_JOBS   = 5;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_COEFF = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_COEFF = 2'd3;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
	localparam logic [COEF_W-1:0] COEF_RESET = 24'd65536;
	localparam logic signed [SUM_W-1:0] ROUND_BIAS = 44'sd32768;

	// queue word: second differences plus pixel tags
	typedef struct packed {
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic                     last_run;
		logic                     last_frame;
	} job_t;

	function automatic logic [1:0] slot_inc(input logic [1:0] s);
		return (s == 2'd2) ? 2'd0 : 2'(s + 2'd1);
	endfunction

	function automatic logic [1:0] slot_dec(input logic [1:0] s);
		return (s == 2'd0) ? 2'd2 : 2'(s - 2'd1);
	endfunction

endpackage

`default_nettype wire

// File: sv/ils_fifo.sv
// ---------------------------------------------------------------------------
// ils_fifo
// Short word queue between the stencil front end and the arithmetic back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "image_laplacian_stencil_top_assert.svh"

module ils_fifo (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire ils_pkg::job_t                  push_job,
	input  wire logic                           pop,
	output ils_pkg::job_t                       head,
	output logic                                empty,
	output logic [ils_pkg::FIFO_CNT_W-1:0]      count
);

	ils_pkg::job_t                     mem_q [ils_pkg::FIFO_DEPTH];
	logic [ils_pkg::FIFO_PTR_W-1:0]    wr_q;
	logic [ils_pkg::FIFO_PTR_W-1:0]    rd_q;
	logic [ils_pkg::FIFO_CNT_W-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ils_pkg::FIFO_PTR_W'(wr_q + 1'b1);
			if (pop)
				rd_q <= ils_pkg::FIFO_PTR_W'(rd_q + 1'b1);
			if (push && !pop)
				cnt_q <= ils_pkg::FIFO_CNT_W'(cnt_q + 1'b1);
			else if (pop && !push)
				cnt_q <= ils_pkg::FIFO_CNT_W'(cnt_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	assign head  = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

	`ILS_ASSERT_NOW(a_fifo_no_overflow, clk, arst_n, push && !pop, cnt_q < ils_pkg::FIFO_CNT_W'(ils_pkg::FIFO_DEPTH), "queue overflow")

endmodule

`default_nettype wire

// File: sv/ils_front.sv
// ---------------------------------------------------------------------------
// ils_front
// Raster counters, three-row line store in nine banks, result sequencing
// and stencil fetch producing the second differences of each result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "image_laplacian_stencil_top_assert.svh"

module ils_front #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic signed [ils_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [ils_pkg::SIZE_W-1:0]        width,
	input  wire logic [ils_pkg::SIZE_W-1:0]        height,
	input  wire logic                              size_clr,
	input  wire logic [ils_pkg::FIFO_CNT_W-1:0]    fifo_count,
	output logic                                   push,
	output ils_pkg::job_t                          push_job
);

	localparam int CW      = $clog2(MAX_WIDTH);
	localparam int RW      = $clog2(MAX_HEIGHT);
	localparam int BANK_D  = MAX_WIDTH / 3 + 1;
	localparam int QW      = $clog2(BANK_D);
	localparam int NJ      = ils_pkg::NUM_JOBS;

	logic [CW:0]   w_eff;
	logic [RW:0]   h_eff;
	logic [CW-1:0] w_m1;
	logic [RW-1:0] h_m1;

	always_comb begin
		if (width < 11'd3)
			w_eff = (CW+1)'(3);
		else if (int'(width) > MAX_WIDTH)
			w_eff = (CW+1)'(MAX_WIDTH);
		else
			w_eff = (CW+1)'(width);
		if (height < 11'd3)
			h_eff = (RW+1)'(3);
		else if (int'(height) > MAX_HEIGHT)
			h_eff = (RW+1)'(MAX_HEIGHT);
		else
			h_eff = (RW+1)'(height);
	end

	assign w_m1 = CW'(w_eff - 1'b1);
	assign h_m1 = RW'(h_eff - 1'b1);

	// raster position of the next sample; column split as quotient and phase by 3
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [1:0]    rs_q;
	logic [QW-1:0] cq_q;
	logic [1:0]    cm_q;

	// item whose results are being issued
	logic [RW-1:0] h_r_q;
	logic [CW-1:0] h_c_q;
	logic [1:0]    h_rs_q;
	logic [QW-1:0] h_cq_q;
	logic [1:0]    h_cm_q;
	logic          h_czero_q;
	logic          h_clast_q;
	logic [NJ-1:0] mask_q;

	logic          s1_v_q;
	logic [NJ-1:0] sel;
	logic [NJ-1:0] rest;
	logic          credit;
	logic          issue;
	logic          accept;
	logic          last_row;
	logic [NJ-1:0] new_mask;

	assign sel    = mask_q & NJ'(-mask_q);
	assign rest   = mask_q & ~sel;
	assign credit = (fifo_count + ils_pkg::FIFO_CNT_W'(s1_v_q))
		< ils_pkg::FIFO_CNT_W'(ils_pkg::FIFO_DEPTH);
	assign issue    = (mask_q != '0) && credit;
	assign in_ready = (mask_q == '0) || (issue && rest == '0);
	assign accept   = in_valid && in_ready;

	assign last_row    = (r_q == h_m1);
	assign new_mask[0] = (r_q == RW'(2));
	assign new_mask[1] = (r_q >= RW'(2));
	assign new_mask[2] = last_row && (c_q == CW'(2));
	assign new_mask[3] = last_row && (c_q >= CW'(2));
	assign new_mask[4] = last_row && (c_q == w_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q    <= '0;
			c_q    <= '0;
			rs_q   <= '0;
			cq_q   <= '0;
			cm_q   <= '0;
			mask_q <= '0;
			s1_v_q <= 1'b0;
		end else begin
			s1_v_q <= issue;
			if (accept)
				mask_q <= new_mask;
			else if (issue)
				mask_q <= rest;
			if (size_clr) begin
				r_q  <= '0;
				c_q  <= '0;
				rs_q <= '0;
				cq_q <= '0;
				cm_q <= '0;
			end else if (accept) begin
				if (c_q == w_m1) begin
					c_q  <= '0;
					cq_q <= '0;
					cm_q <= '0;
					if (last_row) begin
						r_q  <= '0;
						rs_q <= '0;
					end else begin
						r_q  <= RW'(r_q + 1'b1);
						rs_q <= ils_pkg::slot_inc(rs_q);
					end
				end else begin
					c_q <= CW'(c_q + 1'b1);
					if (cm_q == 2'd2) begin
						cq_q <= QW'(cq_q + 1'b1);
						cm_q <= 2'd0;
					end else begin
						cm_q <= 2'(cm_q + 2'd1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h_r_q     <= r_q;
			h_c_q     <= c_q;
			h_rs_q    <= rs_q;
			h_cq_q    <= cq_q;
			h_cm_q    <= cm_q;
			h_czero_q <= (c_q == '0);
			h_clast_q <= (c_q == w_m1);
		end
	end

	// selected result: pixel, its row slot, stencil base column and its own column
	logic [RW-1:0] pr;
	logic [CW-1:0] pc;
	logic [1:0]    prs;
	logic [QW-1:0] bq;
	logic [1:0]    bm;
	logic [QW-1:0] pcq;
	logic [1:0]    pcm;
	logic [QW-1:0] d1q;
	logic [1:0]    d1m;
	logic [QW-1:0] d2q;
	logic [1:0]    d2m;

	always_comb begin
		d1q = (h_cm_q == 2'd0) ? QW'(h_cq_q - 1'b1) : h_cq_q;
		d1m = ils_pkg::slot_dec(h_cm_q);
		d2q = (h_cm_q == 2'd2) ? h_cq_q : QW'(h_cq_q - 1'b1);
		d2m = ils_pkg::slot_dec(d1m);
		pr  = h_r_q;
		prs = h_rs_q;
		pc  = h_c_q;
		pcq = h_cq_q;
		pcm = h_cm_q;
		bq  = d2q;
		bm  = d2m;
		if (sel[0] || sel[1]) begin
			if (sel[0]) begin
				pr  = '0;
				prs = ils_pkg::slot_dec(ils_pkg::slot_dec(h_rs_q));
			end else begin
				pr  = RW'(h_r_q - 1'b1);
				prs = ils_pkg::slot_dec(h_rs_q);
			end
			if (h_czero_q) begin
				bq = '0;
				bm = 2'd0;
			end else if (!h_clast_q) begin
				bq = d1q;
				bm = d1m;
			end
		end else if (sel[2]) begin
			pc  = '0;
			pcq = '0;
			pcm = 2'd0;
			bq  = '0;
			bm  = 2'd0;
		end else if (sel[3]) begin
			pc  = CW'(h_c_q - 1'b1);
			pcq = d1q;
			pcm = d1m;
		end
	end

	logic signed [ils_pkg::SAMPLE_W-1:0] rd_s1 [3][3];

	for (genvar s = 0; s < 3; s++) begin : g_slot
		for (genvar m = 0; m < 3; m++) begin : g_phase
			logic [ils_pkg::SAMPLE_W-1:0] bank [BANK_D];
			logic [QW-1:0]                raddr;

			always_comb begin
				if (prs == 2'(s))
					raddr = (2'(m) >= bm) ? bq : QW'(bq + 1'b1);
				else
					raddr = pcq;
			end

			always_ff @(posedge clk) begin
				if (accept && rs_q == 2'(s) && cm_q == 2'(m))
					bank[cq_q] <= sample;
				rd_s1[s][m] <= bank[raddr];
			end
		end
	end

	ils_pkg::job_t meta_s1;
	logic [1:0]    prs_s1;
	logic [1:0]    bm_s1;
	logic [1:0]    pcm_s1;
	logic [1:0]    rs_s1;

	always_ff @(posedge clk) begin
		if (issue) begin
			meta_s1.dx         <= '0;
			meta_s1.dy         <= '0;
			meta_s1.row        <= ils_pkg::IDX_W'(pr);
			meta_s1.col        <= ils_pkg::IDX_W'(pc);
			meta_s1.last_run   <= (rest == '0);
			meta_s1.last_frame <= sel[4];
			prs_s1             <= prs;
			bm_s1              <= bm;
			pcm_s1             <= pcm;
			rs_s1              <= h_rs_q;
		end
	end

	logic [1:0] m1;
	logic [1:0] m2;
	logic [1:0] s1s;
	logic [1:0] s0s;
	logic signed [ils_pkg::DIFF_W-1:0] xa, xb, xc, ya, yb, yc;

	always_comb begin
		m1  = ils_pkg::slot_inc(bm_s1);
		m2  = ils_pkg::slot_inc(m1);
		s1s = ils_pkg::slot_dec(rs_s1);
		s0s = ils_pkg::slot_dec(s1s);
		xa  = ils_pkg::DIFF_W'(rd_s1[prs_s1][bm_s1]);
		xb  = ils_pkg::DIFF_W'(rd_s1[prs_s1][m1]);
		xc  = ils_pkg::DIFF_W'(rd_s1[prs_s1][m2]);
		ya  = ils_pkg::DIFF_W'(rd_s1[s0s][pcm_s1]);
		yb  = ils_pkg::DIFF_W'(rd_s1[s1s][pcm_s1]);
		yc  = ils_pkg::DIFF_W'(rd_s1[rs_s1][pcm_s1]);
		push_job    = meta_s1;
		push_job.dx = xa - (xb <<< 1) + xc;
		push_job.dy = ya - (yb <<< 1) + yc;
	end

	assign push = s1_v_q;

	`ILS_ASSERT_NOW(a_issue_onehot, clk, arst_n, issue, $onehot(sel), "issued job not one-hot")
	`ILS_ASSERT_NEXT(a_item_retires, clk, arst_n, issue && rest == '0 && !accept, mask_q == '0, "item not retired after last job")

endmodule

`default_nettype wire

// File: sv/ils_back.sv
// ---------------------------------------------------------------------------
// ils_back
// Coefficient multiply, rounding and result register with stall control.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "image_laplacian_stencil_top_assert.svh"

module ils_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ils_pkg::job_t                     head,
	input  wire logic                              empty,
	output logic                                   pop,
	input  wire logic [ils_pkg::COEF_W-1:0]        x_coeff,
	input  wire logic [ils_pkg::COEF_W-1:0]        y_coeff,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [ils_pkg::RES_W-1:0]       result_value,
	output logic [ils_pkg::IDX_W-1:0]              result_row,
	output logic [ils_pkg::IDX_W-1:0]              result_col,
	output logic                                   last_of_run,
	output logic                                   last_of_frame
);

	localparam int Q_W = ils_pkg::SUM_W - ils_pkg::FRAC_W;

	logic signed [ils_pkg::COEF_W:0]       cx;
	logic signed [ils_pkg::COEF_W:0]       cy;
	logic                                  en;
	logic                                  s2_v_q;
	logic signed [ils_pkg::PROD_W-1:0]     px_s2;
	logic signed [ils_pkg::PROD_W-1:0]     py_s2;
	ils_pkg::job_t                         tag_s2;
	logic                                  out_v_q;
	logic signed [ils_pkg::SUM_W-1:0]      sum;
	logic signed [Q_W-1:0]                 q;

	assign cx  = {1'b0, x_coeff};
	assign cy  = {1'b0, y_coeff};
	assign en  = !out_v_q || out_ready;
	assign pop = en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			s2_v_q  <= pop;
			out_v_q <= s2_v_q;
		end
	end

	always_comb begin
		sum = ils_pkg::SUM_W'(px_s2) + ils_pkg::SUM_W'(py_s2) + ils_pkg::ROUND_BIAS;
		q   = sum[ils_pkg::SUM_W-1:ils_pkg::FRAC_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2         <= head.dx * cx;
			py_s2         <= head.dy * cy;
			tag_s2        <= head;
			result_value  <= ils_pkg::RES_W'(q);
			result_row    <= tag_s2.row;
			result_col    <= tag_s2.col;
			last_of_run   <= tag_s2.last_run;
			last_of_frame <= tag_s2.last_frame;
		end
	end

	assign out_valid = out_v_q;

	`ILS_ASSERT_NEXT(a_pipe_advance, clk, arst_n, en && s2_v_q, out_v_q, "product stage lost on advance")

endmodule

`default_nettype wire

// File: sv/image_laplacian_stencil_top.sv
// ---------------------------------------------------------------------------
// image_laplacian_stencil_top
// Streaming five-point half Laplacian with one-sided differences at borders.
// ---------------------------------------------------------------------------
// Samples arrive in raster order, one word per cycle at most; the block emits
// one result word per cycle at most. An input that releases k results holds
// the front end until its last result is fetched (k is 0 on rows 0 and 1, 1
// on most rows, 2 on row 2, 1 to 4 on the last row, and up to 5 when row 2 is
// the last row): the single stencil fetch port of the nine-bank line store
// serves one result per cycle while the queue has room. Fetched results pass
// a fetch register, then a 4-word queue that decouples fetch from the
// multiply and result registers, so output stalls do not block the line
// store until the queue fills. Writing width or height restarts the frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module image_laplacian_stencil_top #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [ils_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [ils_pkg::COEF_W-1:0]           cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic signed [ils_pkg::SAMPLE_W-1:0]  sample,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [ils_pkg::RES_W-1:0]          result_value,
	output logic [ils_pkg::IDX_W-1:0]                 result_row,
	output logic [ils_pkg::IDX_W-1:0]                 result_col,
	output logic                                      last_of_run,
	output logic                                      last_of_frame
);

	logic [ils_pkg::SIZE_W-1:0]     width_q;
	logic [ils_pkg::SIZE_W-1:0]     height_q;
	logic [ils_pkg::COEF_W-1:0]     x_coeff_q;
	logic [ils_pkg::COEF_W-1:0]     y_coeff_q;
	logic                           size_clr;
	logic                           push;
	ils_pkg::job_t                  push_job;
	ils_pkg::job_t                  head;
	logic                           pop;
	logic                           empty;
	logic [ils_pkg::FIFO_CNT_W-1:0] fifo_count;

	assign cfg_ready = 1'b1;
	assign size_clr  = cfg_valid
		&& (cfg_index == ils_pkg::REG_WIDTH || cfg_index == ils_pkg::REG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= ils_pkg::SIZE_RESET;
			height_q  <= ils_pkg::SIZE_RESET;
			x_coeff_q <= ils_pkg::COEF_RESET;
			y_coeff_q <= ils_pkg::COEF_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				ils_pkg::REG_WIDTH:   width_q   <= cfg_data[ils_pkg::SIZE_W-1:0];
				ils_pkg::REG_HEIGHT:  height_q  <= cfg_data[ils_pkg::SIZE_W-1:0];
				ils_pkg::REG_X_COEFF: x_coeff_q <= cfg_data;
				ils_pkg::REG_Y_COEFF: y_coeff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ils_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.width      (width_q),
		.height     (height_q),
		.size_clr   (size_clr),
		.fifo_count (fifo_count),
		.push       (push),
		.push_job   (push_job)
	);

	ils_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.count    (fifo_count)
	);

	ils_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.x_coeff       (x_coeff_q),
		.y_coeff       (y_coeff_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_value  (result_value),
		.result_row    (result_row),
		.result_col    (result_col),
		.last_of_run   (last_of_run),
		.last_of_frame (last_of_frame)
	);

endmodule

`default_nettype wire

// File: sim/image_laplacian_stencil_top_tb.sv
// ---------------------------------------------------------------------------
// image_laplacian_stencil_top_tb
// Self-checking bench for the streaming five-point half Laplacian.
// ---------------------------------------------------------------------------
// A directed table opens the run. It covers the smallest frame, flat and
// full-swing data, and the largest coefficients. Random phases follow. Each phase
// sets a size and coefficients, mostly small whole frames, with some partial
// frames and clamped sizes. Every output word is checked against an
// in-bench line-store predictor, with random stalls on both sides and one
// long output hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module image_laplacian_stencil_top_tb;

	localparam int MAXW = 1024;
	localparam int MAXH = 1024;
	localparam int N_ITEMS = 450;
	localparam int WDOG_LIMIT = 4000;

	typedef struct {
		logic signed [ils_pkg::RES_W-1:0] value;
		logic [ils_pkg::IDX_W-1:0]        row;
		logic [ils_pkg::IDX_W-1:0]        col;
		logic                             run_end;
		logic                             frame_end;
	} pix_res_t;

	typedef struct {
		bit                                  is_cfg;
		logic [ils_pkg::CFG_IDX_W-1:0]       idx;
		logic [ils_pkg::COEF_W-1:0]          data;
		logic signed [ils_pkg::SAMPLE_W-1:0] smp;
		bit                                  flat;
	} stim_row_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [ils_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ils_pkg::COEF_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [ils_pkg::SAMPLE_W-1:0] sample;
	logic out_valid, out_ready;
	logic signed [ils_pkg::RES_W-1:0] result_value;
	logic [ils_pkg::IDX_W-1:0] result_row, result_col;
	logic last_of_run, last_of_frame;

	pix_res_t pending_q[$];
	stim_row_t dir_tab[$];
	logic signed [ils_pkg::SAMPLE_W-1:0] line_mem [0:3*MAXW-1];
	int unsigned cur_row, cur_col, size_w_reg, size_h_reg, xc_reg, yc_reg;
	int errors, words_in, words_out, cfg_writes, frames_done;
	bit calm, hold_req;

	image_laplacian_stencil_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_value(result_value), .result_row(result_row),
		.result_col(result_col), .last_of_run(last_of_run),
		.last_of_frame(last_of_frame)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned maxv);
		if (v < 3) return 3;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic int unsigned mid_pos(int unsigned p, int unsigned n);
		if (p < 1) return 1;
		if (p > n - 2) return n - 2;
		return p;
	endfunction

	function automatic longint line_at(int unsigned r, int unsigned c);
		return longint'(line_mem[(r % 3) * MAXW + (c % MAXW)]);
	endfunction

	function automatic logic signed [ils_pkg::RES_W-1:0] half_lap(int unsigned r,
			int unsigned c, int unsigned w, int unsigned h);
		int unsigned cc, rc;
		longint dx, dy, acc;
		cc = mid_pos(c, w);
		rc = mid_pos(r, h);
		dx = line_at(r, cc - 1) - 2 * line_at(r, cc) + line_at(r, cc + 1);
		dy = line_at(rc - 1, c) - 2 * line_at(rc, c) + line_at(rc + 1, c);
		acc = (dx * longint'(xc_reg) + dy * longint'(yc_reg) + 32768) >>> 16;
		if (acc > 64'sd2147483647) acc = 64'sd2147483647;
		if (acc < -64'sd2147483648) acc = -64'sd2147483648;
		return acc[ils_pkg::RES_W-1:0];
	endfunction

	function automatic void push_pix(int unsigned r, int unsigned c, int unsigned w,
			int unsigned h);
		pix_res_t p;
		p.value = half_lap(r, c, w, h);
		p.row = r[ils_pkg::IDX_W-1:0];
		p.col = c[ils_pkg::IDX_W-1:0];
		p.run_end = 1'b0;
		p.frame_end = (r == h - 1 && c == w - 1);
		pending_q.push_back(p);
	endfunction

	// flat: every word this sample releases is known to be zero
	function automatic void stencil_step(logic signed [ils_pkg::SAMPLE_W-1:0] s, bit flat);
		int unsigned w, h, r, c, n0;
		w = clamp_dim(size_w_reg, MAXW);
		h = clamp_dim(size_h_reg, MAXH);
		if (cur_col >= w || cur_row >= h) begin
			cur_row = 0;
			cur_col = 0;
		end
		r = cur_row;
		c = cur_col;
		line_mem[(r % 3) * MAXW + c] = s;
		n0 = pending_q.size();
		if (r >= 2) begin
			if (r == 2) push_pix(0, c, w, h);
			push_pix(r - 1, c, w, h);
		end
		if (r == h - 1 && c >= 2) begin
			if (c == 2) push_pix(r, 0, w, h);
			push_pix(r, c - 1, w, h);
			if (c == w - 1) push_pix(r, c, w, h);
		end
		if (pending_q.size() > n0) pending_q[$].run_end = 1'b1;
		if (flat)
			for (int i = n0; i < pending_q.size(); i++) pending_q[i].value = '0;
		cur_col = c + 1;
		if (cur_col >= w) begin
			cur_col = 0;
			cur_row = r + 1;
			if (cur_row >= h) begin
				cur_row = 0;
				frames_done++;
			end
		end
	endfunction

	function automatic void apply_cfg(logic [ils_pkg::CFG_IDX_W-1:0] idx,
			logic [ils_pkg::COEF_W-1:0] d);
		case (idx)
			ils_pkg::REG_WIDTH: begin
				size_w_reg = d[ils_pkg::SIZE_W-1:0];
				cur_row = 0;
				cur_col = 0;
			end
			ils_pkg::REG_HEIGHT: begin
				size_h_reg = d[ils_pkg::SIZE_W-1:0];
				cur_row = 0;
				cur_col = 0;
			end
			ils_pkg::REG_X_COEFF: xc_reg = d;
			ils_pkg::REG_Y_COEFF: yc_reg = d;
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch %s at word %0d: got %0d, expected %0d", what, words_out, got,
			want);
	endtask

	function automatic int unsigned gap_draw();
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic logic signed [ils_pkg::SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			1: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(logic [ils_pkg::CFG_IDX_W-1:0] idx,
			logic [ils_pkg::COEF_W-1:0] d);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_cfg(idx, d);
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// called at a falling edge; returns at a falling edge
	task automatic send_word(logic signed [ils_pkg::SAMPLE_W-1:0] s, bit flat);
		int unsigned g;
		g = gap_draw();
		if (g > 0) begin
			in_valid = 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid = 1'b1;
		sample = s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		stencil_step(s, flat);
		words_in++;
		if (words_in == 150) hold_req = 1'b1;
		if (words_in % 40 == 0) calm = ($urandom_range(0, 3) == 0);
		@(negedge clk);
	endtask

	task automatic size_phase(logic [ils_pkg::SIZE_W-1:0] w, logic [ils_pkg::SIZE_W-1:0] h,
			int n);
		write_reg(ils_pkg::REG_WIDTH, {13'($urandom), w});
		write_reg(ils_pkg::REG_HEIGHT, {13'($urandom), h});
		case ($urandom_range(0, 3))
			0: write_reg(ils_pkg::REG_X_COEFF, $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0);
			default: write_reg(ils_pkg::REG_X_COEFF, 24'($urandom));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(ils_pkg::REG_Y_COEFF, $urandom_range(0, 1) ? 24'hFFFFFF : 24'h0);
			default: write_reg(ils_pkg::REG_Y_COEFF, 24'($urandom));
		endcase
		@(negedge clk);
		for (int i = 0; i < n && words_in < N_ITEMS; i++) send_word(rand_sample(), 1'b0);
		in_valid = 1'b0;
	endtask

	// receiver
	initial begin
		int unsigned stall_left, hold_left;
		stall_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					errors++;
					$display("unexpected word: row %0d col %0d value %0d", result_row,
						result_col, result_value);
				end else begin
					pix_res_t e;
					e = pending_q.pop_front();
					if (result_value !== e.value)
						report_mismatch("result_value", result_value, e.value);
					if (result_row !== e.row) report_mismatch("result_row", result_row, e.row);
					if (result_col !== e.col) report_mismatch("result_col", result_col, e.col);
					if (last_of_run !== e.run_end)
						report_mismatch("last_of_run", last_of_run, e.run_end);
					if (last_of_frame !== e.frame_end)
						report_mismatch("last_of_frame", last_of_frame, e.frame_end);
				end
				words_out++;
				stall_left = gap_draw();
			end
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else
				out_ready = 1'b1;
		end
	end

	// watchdog: cycles with no word moved on any channel
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("[image_laplacian_stencil_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned w, h;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		words_in = 0;
		words_out = 0;
		cfg_writes = 0;
		frames_done = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		cur_row = 0;
		cur_col = 0;
		size_w_reg = ils_pkg::SIZE_RESET;
		size_h_reg = ils_pkg::SIZE_RESET;
		xc_reg = ils_pkg::COEF_RESET;
		yc_reg = ils_pkg::COEF_RESET;
		for (int i = 0; i < 3 * MAXW; i++) line_mem[i] = '0;

		dir_tab.push_back('{1'b1, ils_pkg::REG_WIDTH, 24'd3, 16'sd0, 1'b0});
		dir_tab.push_back('{1'b1, ils_pkg::REG_HEIGHT, 24'd3, 16'sd0, 1'b0});
		for (int i = 0; i < 9; i++)
			dir_tab.push_back('{1'b0, ils_pkg::REG_WIDTH, 24'd0, 16'sh7FFF, 1'b1});
		dir_tab.push_back('{1'b1, ils_pkg::REG_X_COEFF, 24'hFFFFFF, 16'sd0, 1'b0});
		dir_tab.push_back('{1'b1, ils_pkg::REG_Y_COEFF, 24'hFFFFFF, 16'sd0, 1'b0});
		for (int i = 0; i < 9; i++)
			dir_tab.push_back('{1'b0, ils_pkg::REG_WIDTH, 24'd0,
				(i % 2) ? 16'sh7FFF : 16'sh8000, 1'b0});

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				in_valid = 1'b0;
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else
				send_word(dir_tab[i].smp, dir_tab[i].flat);
		end
		in_valid = 1'b0;

		while (words_in < N_ITEMS) begin
			case ($urandom_range(0, 9))
				0: size_phase($urandom_range(0, 1) ? 11'd2047 : 11'd1024, 11'd3, 30);
				1: size_phase(11'd3, $urandom_range(0, 1) ? 11'd2047 : 11'd0, 24);
				default: begin
					w = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 8);
					h = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2) : $urandom_range(3, 8);
					if ($urandom_range(0, 4) == 0)
						size_phase(w, h, $urandom_range(1, 30));
					else
						size_phase(w, h, clamp_dim(w, MAXW) * clamp_dim(h, MAXH) *
							$urandom_range(1, 2));
				end
			endcase
		end

		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("run covered %0d samples, %0d result words, %0d register writes", words_in,
			words_out, cfg_writes);
		$display("%0d whole frames, one long output hold-off", frames_done);
		if (errors == 0)
			$display("[image_laplacian_stencil_top] OK");
		else
			$display("[image_laplacian_stencil_top] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: image_laplacian_stencil_top.f
+incdir+sv
sv/ils_pkg.sv
sv/ils_fifo.sv
sv/ils_front.sv
sv/ils_back.sv
sv/image_laplacian_stencil_top.sv
sim/image_laplacian_stencil_top_tb.sv
